// ----- rtl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;
   localparam logic [20:0] CP_ASCII   = 21'h00007F;
   localparam logic [20:0] CP_TWO     = 21'h0007FF;
   localparam logic [20:0] CP_BMP     = 21'h00FFFF;
   localparam logic [10:0] PLANE_ONE  = 11'd64;

   localparam logic        REPLACE_MODE_RST = 1'b1;
   localparam logic [20:0] REPLACEMENT_RST  = 21'h00FFFD;

   typedef enum logic [0:0] {
      CSR_REPLACE_MODE     = 1'b0,
      CSR_REPLACEMENT_CODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } enc_type;

   typedef struct packed {
      enc_type first;
      enc_type second;
      logic    last;
      logic    fail;
   } job_type;

   function automatic enc_type utf8_encode(input logic [20:0] cp, input logic en);
      enc_type e;
      e.bytes = '0;
      e.len   = 3'd0;
      if (!en) begin
         e.len = 3'd0;
      end else if (cp <= CP_ASCII) begin
         e.bytes[0] = {1'b0, cp[6:0]};
         e.len      = 3'd1;
      end else if (cp <= CP_TWO) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.len      = 3'd2;
      end else if (cp <= CP_BMP) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.len      = 3'd3;
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.len      = 3'd4;
      end
      return e;
   endfunction

endpackage

// ----- rtl/u16u8_decode.sv -----
// ----------------------------------------------------------------------------
// u16u8_decode
// Surrogate pairing, error handling and UTF-8 encoding of one code unit.
// Holds the pending high surrogate and the discard flag.
// ----------------------------------------------------------------------------
module u16u8_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [15:0]         code_unit,
   input  logic                last_unit,
   input  logic                replace_mode,
   input  logic [20:0]         replacement_code,
   output u16u8_pkg::job_type  job,
   output logic                job_has
);
   import u16u8_pkg::*;

   logic        pend_ff, pend_in;
   logic [9:0]  high_ff, high_in;
   logic        disc_ff, disc_in;

   logic        is_high, is_low, is_surr;
   logic        rc_bad, fail_cfg, pair, pend_fail, hold_new, unit_fail, fail;
   logic        cp1_en, cp2_en;
   logic [20:0] pair_cp, cp1, cp2;

   always_comb begin
      is_high   = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
      is_low    = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
      is_surr   = is_high || is_low;
      rc_bad    = (replacement_code > CP_MAX) ||
                  ((replacement_code >= {5'd0, HIGH_FIRST}) &&
                   (replacement_code <= {5'd0, LOW_LAST}));
      fail_cfg  = replace_mode && rc_bad;
      pair      = pend_ff && is_low;
      pend_fail = !fail_cfg && pend_ff && !is_low && !replace_mode;
      hold_new  = !pair && is_high && !last_unit;
      unit_fail = !fail_cfg && !pend_fail && !pair && !hold_new && is_surr && !replace_mode;
      fail      = fail_cfg || pend_fail || unit_fail;
      cp1_en    = pend_ff && !fail_cfg && (is_low || replace_mode);
      cp2_en    = !fail && !pair && !hold_new;
      pair_cp   = {({1'b0, high_ff} + PLANE_ONE), code_unit[9:0]};
      cp1       = is_low ? pair_cp : replacement_code;
      cp2       = is_surr ? replacement_code : {5'd0, code_unit};
   end

   always_comb begin
      job.last = last_unit;
      job.fail = fail;
      if (fail) begin
         job.first.bytes  = '0;
         job.first.len    = 3'd1;
         job.second.bytes = '0;
         job.second.len   = 3'd0;
      end else begin
         job.first  = utf8_encode(cp1, cp1_en);
         job.second = utf8_encode(cp2, cp2_en);
      end
      job_has = !disc_ff && (fail || cp1_en || cp2_en);
   end

   always_comb begin
      pend_in = pend_ff;
      high_in = high_ff;
      disc_in = disc_ff;
      if (accept) begin
         if (disc_ff) begin
            disc_in = !last_unit;
         end else begin
            disc_in = fail && !last_unit;
            pend_in = !fail && hold_new;
            if (hold_new) begin
               high_in = code_unit[9:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         high_ff <= '0;
         disc_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         high_ff <= high_in;
         disc_ff <= disc_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pend_while_disc: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && disc_ff))
      else $error("pending surrogate held while discarding");
   a_disc_no_results: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> !job_has)
      else $error("result produced while discarding");
   a_fail_clears_pend: assert property (@(posedge clock) disable iff (reset)
      (accept && job_has && job.fail) |=> !pend_ff)
      else $error("pending surrogate survived a failure");
`endif

endmodule

// ----- rtl/u16u8_serial.sv -----
// ----------------------------------------------------------------------------
// u16u8_serial
// Result register with skid slot; sends the bytes of one job one per
// transfer.
// ----------------------------------------------------------------------------
module u16u8_serial (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  u16u8_pkg::job_type  job,
   output logic                ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_byte
   output logic                rsp_tlast,   // message_end
   output logic [1:0]          rsp_tuser    // [0] run_end, [1] failed
);
   import u16u8_pkg::*;

   job_type     main_ff, main_in, skid_ff, skid_in;
   logic        main_vld_ff, main_vld_in, skid_vld_ff, skid_vld_in;
   logic [2:0]  idx_ff, idx_in;
   logic [3:0]  total;
   logic [2:0]  sel;
   logic        run_end, take, fin;

   always_comb begin
      total   = {1'b0, main_ff.first.len} + {1'b0, main_ff.second.len};
      run_end = ({1'b0, idx_ff} == (total - 4'd1));
      sel     = idx_ff - main_ff.first.len;
      if (idx_ff < main_ff.first.len) begin
         rsp_tdata = main_ff.first.bytes[idx_ff[1:0]];
      end else begin
         rsp_tdata = main_ff.second.bytes[sel[1:0]];
      end
      rsp_tvalid   = main_vld_ff;
      rsp_tlast    = run_end && (main_ff.last || main_ff.fail);
      rsp_tuser[0] = run_end;
      rsp_tuser[1] = main_ff.fail;
      ready        = !skid_vld_ff;
      take         = main_vld_ff && rsp_tready;
      fin          = take && run_end;
   end

   always_comb begin
      main_in     = main_ff;
      main_vld_in = main_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      idx_in      = idx_ff;
      if (take) begin
         idx_in = idx_ff + 3'd1;
      end
      if (fin) begin
         main_vld_in = 1'b0;
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            main_vld_in = 1'b1;
            skid_vld_in = 1'b0;
            idx_in      = 3'd0;
         end
      end
      if (load) begin
         if (!main_vld_ff || fin) begin
            main_in     = job;
            main_vld_in = 1'b1;
            idx_in      = 3'd0;
         end else begin
            skid_in     = job;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
         idx_ff      <= idx_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      main_vld_ff |-> ({1'b0, idx_ff} < total))
      else $error("byte index past end of job");
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (main_vld_ff && main_ff.fail) |-> (total == 4'd1) && (idx_ff == 3'd0))
      else $error("error job with more than one result");
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid slot filled while result register empty");
`endif

endmodule

// ----- rtl/utf16_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing, replacement
// or rejection of unpaired surrogates and per-message error reporting.
//
//   channel  dir  payload
//   req_     in   tdata[15:0] code_unit, tlast last_unit
//   rsp_     out  tdata[7:0] out_byte, tuser[0] run_end, tuser[1] failed,
//                 tlast message_end
//   csr_     in   index 0 replace_mode, 1 replacement_code, data[20:0]
//
// One byte per cycle on rsp_ unless it stalls; a code unit makes 0 to 8
// bytes, sent by the result serializer. A unit making no bytes or one byte is
// taken every cycle unless rsp_ stalls. Decode is combinational up to the
// result register. A skid slot keeps req_tready registered; while rsp_ stalls
// at most one further unit with results is taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // last_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // message_end
   output logic [1:0]  rsp_tuser,   // [0] run_end, [1] failed
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_data
);
   import u16u8_pkg::*;

   logic        mode_ff, mode_in;
   logic [20:0] code_ff, code_in;
   logic        accept, job_has, ready;
   job_type     job;

   assign csr_ready  = 1'b1;
   assign req_tready = ready;
   assign accept     = req_tvalid && ready;

   always_comb begin
      mode_in = mode_ff;
      code_in = code_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REPLACE_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_REPLACEMENT_CODE: begin
               code_in = csr_data;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= REPLACE_MODE_RST;
         code_ff <= REPLACEMENT_RST;
      end else begin
         mode_ff <= mode_in;
         code_ff <= code_in;
      end
   end

   u16u8_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .code_unit        (req_tdata),
      .last_unit        (req_tlast),
      .replace_mode     (mode_ff),
      .replacement_code (code_ff),
      .job              (job),
      .job_has          (job_has)
   );

   u16u8_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && job_has),
      .job        (job),
      .ready      (ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf16_to_utf8_transcoder. A directed table covers
// encoding extremes, surrogate pairing, unpaired surrogates, reject mode and
// an invalid replacement code. Random messages then run under several register
// settings and idle/stall patterns. Every output byte is checked against the
// table's expected bytes or a transcoder model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
   import u16u8_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 150;
   localparam int MAX_REPORTS    = 50;

   typedef enum {ROW_UNIT, ROW_CFG} row_kind_type;
   typedef enum {CHK_MODEL, CHK_BYTES, CHK_ERROR} row_check_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       msg_end;
      logic       failed;
   } utf8_result_type;

   typedef struct {
      row_kind_type  kind;
      logic [15:0]   unit;
      logic          is_last;
      row_check_type check;
      int            n_bytes;
      logic [63:0]   bytes;    // first byte in the highest used bits
      logic          mode;
      logic [20:0]   code;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index  = '0;
   logic [20:0] csr_data   = '0;

   utf16_to_utf8_transcoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // transcoder model state
   logic            cfg_replace   = REPLACE_MODE_RST;
   logic [20:0]     cfg_code      = REPLACEMENT_RST;
   logic            held_valid    = 1'b0;
   logic [9:0]      held_bits     = '0;
   logic            dropping      = 1'b0;
   logic [7:0]      step_bytes[$];
   logic            step_fail;
   utf8_result_type expected_bytes[$];

   // what the unit on the bus is checked against
   row_check_type row_check = CHK_MODEL;
   int            row_n     = 0;
   logic [63:0]   row_bytes = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_rsp      = 1'b0;

   int mismatch_count  = 0;
   int units_sent      = 0;
   int messages_sent   = 0;
   int bytes_checked   = 0;
   int errors_expected = 0;
   int csr_writes      = 0;
   int stall_cycles    = 0;

   stim_row_type directed_rows[$];

   function automatic logic code_invalid(input logic [20:0] cp);
      return cp > CP_MAX || (cp >= 21'(HIGH_FIRST) && cp <= 21'(LOW_LAST));
   endfunction

   function automatic void append_step_byte(input logic [7:0] b);
      step_bytes.insert(step_bytes.size(), b);
   endfunction

   function automatic void append_expected(input utf8_result_type r);
      expected_bytes.insert(expected_bytes.size(), r);
   endfunction

   function automatic void append_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void encode_cp(input logic [20:0] cp);
      if (cp <= CP_ASCII) begin
         append_step_byte({1'b0, cp[6:0]});
      end else if (cp <= CP_TWO) begin
         append_step_byte({3'b110, cp[10:6]});
         append_step_byte({2'b10, cp[5:0]});
      end else if (cp <= CP_BMP) begin
         append_step_byte({4'b1110, cp[15:12]});
         append_step_byte({2'b10, cp[11:6]});
         append_step_byte({2'b10, cp[5:0]});
      end else begin
         append_step_byte({5'b11110, cp[20:18]});
         append_step_byte({2'b10, cp[17:12]});
         append_step_byte({2'b10, cp[11:6]});
         append_step_byte({2'b10, cp[5:0]});
      end
   endfunction

   // Leaves the bytes of one code unit in step_bytes, or step_fail set.
   function automatic void transcode_unit(input logic [15:0] unit, input logic is_last);
      logic is_high;
      logic is_low;
      logic used;
      step_bytes.delete();
      step_fail = 1'b0;
      if (dropping) begin
         if (is_last) dropping = 1'b0;
         return;
      end
      is_high   = unit >= HIGH_FIRST && unit <= HIGH_LAST;
      is_low    = unit >= LOW_FIRST && unit <= LOW_LAST;
      used      = 1'b0;
      step_fail = cfg_replace && code_invalid(cfg_code);
      if (!step_fail && held_valid) begin
         if (is_low) begin
            encode_cp(21'h10000 + {1'b0, held_bits, unit[9:0]});
            held_valid = 1'b0;
            used = 1'b1;
         end else if (cfg_replace) begin
            encode_cp(cfg_code);
            held_valid = 1'b0;
         end else begin
            step_fail = 1'b1;
         end
      end
      if (!step_fail && !used) begin
         if (is_high && !is_last) begin
            held_valid = 1'b1;
            held_bits  = unit[9:0];
         end else if (is_high || is_low) begin
            if (cfg_replace) encode_cp(cfg_code);
            else step_fail = 1'b1;
         end else begin
            encode_cp({5'b0, unit});
         end
      end
      if (step_fail) begin
         held_valid = 1'b0;
         dropping   = !is_last;
         step_bytes.delete();
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h",
                  $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : monitor
      int k;
      utf8_result_type want;
      utf8_result_type item;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REPLACE_MODE) cfg_replace = csr_data[0];
            else cfg_code = csr_data;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            transcode_unit(req_tdata, req_tlast);
            if (row_check != CHK_MODEL) begin
               step_fail = row_check == CHK_ERROR;
               step_bytes.delete();
               for (k = 0; k < row_n; k++)
                  append_step_byte(row_bytes[8 * (row_n - 1 - k) +: 8]);
            end
            if (step_fail) begin
               item = '{8'h00, 1'b1, 1'b1, 1'b1};
               append_expected(item);
               errors_expected++;
            end else begin
               foreach (step_bytes[j]) begin
                  item = '{step_bytes[j], j == step_bytes.size() - 1,
                           j == step_bytes.size() - 1 && req_tlast, 1'b0};
                  append_expected(item);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected transfer, out_byte", int'(rsp_tdata), 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch("out_byte", int'(rsp_tdata), int'(want.data));
               if (rsp_tuser[0] !== want.run_end)
                  report_mismatch("run_end", int'(rsp_tuser[0]), int'(want.run_end));
               if (rsp_tlast !== want.msg_end)
                  report_mismatch("message_end", int'(rsp_tlast), int'(want.msg_end));
               if (rsp_tuser[1] !== want.failed)
                  report_mismatch("failed", int'(rsp_tuser[1]), int'(want.failed));
            end
            bytes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_unit(input logic [15:0] unit, input logic is_last,
                            input row_check_type chk, input int n,
                            input logic [63:0] bytes);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= is_last;
      row_check  = chk;
      row_n      = n;
      row_bytes  = bytes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      units_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic mode, input logic [20:0] code);
      csr_valid <= 1'b1;
      csr_index <= CSR_REPLACE_MODE;
      csr_data  <= {20'b0, mode};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_REPLACEMENT_CODE;
      csr_data  <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_unit(input logic [15:0] unit, input logic is_last,
                                    input row_check_type chk, input int n,
                                    input logic [63:0] bytes);
      stim_row_type row;
      row = '{ROW_UNIT, unit, is_last, chk, n, bytes, 1'b0, 21'd0};
      append_row(row);
   endfunction

   function automatic void add_cfg(input logic mode, input logic [20:0] code);
      stim_row_type row;
      row = '{ROW_CFG, 16'd0, 1'b0, CHK_MODEL, 0, 64'd0, mode, code};
      append_row(row);
   endfunction

   task automatic send_random_message();
      int len;
      int k;
      int pick;
      logic [15:0] u;
      len = $urandom_range(1, 6);
      k = 0;
      while (k < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            u = 16'($urandom_range(0, 16'h7F));
         end else if (pick < 35) begin
            u = 16'($urandom_range(16'h80, 16'h7FF));
         end else if (pick < 55) begin
            u = 16'($urandom_range(16'h800, 16'hFFFF));
            if (u >= HIGH_FIRST && u <= LOW_LAST) u = u ^ 16'h4000;
         end else if (pick < 80) begin
            if (k == len - 1) len++;
            send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0, CHK_MODEL, 0, '0);
            k++;
            u = 16'($urandom_range(LOW_FIRST, LOW_LAST));
         end else if (pick < 87) begin
            u = 16'($urandom_range(LOW_FIRST, LOW_LAST));
         end else if (pick < 93) begin
            u = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
         end else begin
            u = 16'($urandom_range(0, 16'hFFFF));
         end
         send_unit(u, k == len - 1, CHK_MODEL, 0, '0);
         k++;
      end
      messages_sent++;
   endtask

   task automatic run_phase(input logic mode, input logic [20:0] code, input int idle_pct,
                            input int stall_pct, input int n_units, input bit pressure);
      int stop_at;
      wait_drained();
      set_config(mode, code);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (pressure) begin
         fork
            begin
               @(posedge clock);
               hold_rsp = 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_rsp = 1'b0;
            end
         join_none
      end
      stop_at = units_sent + n_units;
      while (units_sent < stop_at) send_random_message();
   endtask

   initial begin : stimulus
      logic [20:0] any_code;
      // replacement EF BF BD is U+FFFD, the reset code
      add_unit(16'h0000, 1'b1, CHK_BYTES, 1, 64'h00);
      add_unit(16'h007F, 1'b1, CHK_BYTES, 1, 64'h7F);
      add_unit(16'h0080, 1'b0, CHK_BYTES, 2, 64'hC280);
      add_unit(16'h07FF, 1'b0, CHK_BYTES, 2, 64'hDFBF);
      add_unit(16'h0800, 1'b0, CHK_BYTES, 3, 64'hE0A080);
      add_unit(16'hFFFF, 1'b1, CHK_BYTES, 3, 64'hEFBFBF);
      add_unit(16'hD800, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'hDC00, 1'b1, CHK_MODEL, 0, 64'h0);
      add_unit(16'hDBFF, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'hDFFF, 1'b1, CHK_MODEL, 0, 64'h0);
      add_unit(16'hDC00, 1'b1, CHK_BYTES, 3, 64'hEFBFBD);
      add_unit(16'hD800, 1'b1, CHK_BYTES, 3, 64'hEFBFBD);
      add_unit(16'hDBFF, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'h0041, 1'b1, CHK_BYTES, 4, 64'hEFBFBD41);
      add_unit(16'hD800, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'hDBFF, 1'b0, CHK_BYTES, 3, 64'hEFBFBD);
      add_unit(16'hFFFF, 1'b1, CHK_BYTES, 6, 64'hEFBFBDEFBFBF);
      add_cfg(1'b0, 21'h00FFFD);
      add_unit(16'hDC00, 1'b0, CHK_ERROR, 0, 64'h0);
      add_unit(16'h0042, 1'b1, CHK_BYTES, 0, 64'h0);
      add_unit(16'hD800, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'h0041, 1'b1, CHK_ERROR, 0, 64'h0);
      add_cfg(1'b1, 21'h00D800);
      add_unit(16'h0041, 1'b0, CHK_ERROR, 0, 64'h0);
      add_unit(16'h0042, 1'b1, CHK_BYTES, 0, 64'h0);
      add_cfg(1'b1, 21'h10FFFF);
      add_unit(16'hDBFF, 1'b0, CHK_BYTES, 0, 64'h0);
      add_unit(16'hDBFE, 1'b1, CHK_MODEL, 0, 64'h0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            wait_drained();
            set_config(directed_rows[i].mode, directed_rows[i].code);
         end else begin
            send_unit(directed_rows[i].unit, directed_rows[i].is_last, directed_rows[i].check,
                      directed_rows[i].n_bytes, directed_rows[i].bytes);
         end
      end

      run_phase(1'b1, 21'h00FFFD, 0, 0, 45, 1'b0);
      run_phase(1'b0, 21'h000000, 84, 0, 45, 1'b0);
      run_phase(1'b1, 21'h10FFFF, 0, 84, 45, 1'b1);
      run_phase(1'b1, 21'h1FFFFF, 34, 34, 20, 1'b0);
      run_phase(1'b1, 21'h000000, 0, 0, 45, 1'b0);
      run_phase(1'b0, 21'h0007FF, 84, 0, 45, 1'b0);
      any_code = 21'($urandom_range(0, 21'h10FFFF));
      if (code_invalid(any_code)) any_code = any_code - 21'h800;
      run_phase(1'b1, any_code, 0, 84, 45, 1'b0);
      run_phase(1'b1, 21'($urandom_range(0, 21'h1FFFFF)), 34, 34, 45, 1'b0);

      wait_drained();
      $display("Sent %0d code units in %0d random messages plus the directed table",
               units_sent, messages_sent);
      $display("Checked %0d output bytes (%0d error results) over %0d register writes",
               bytes_checked, errors_expected, csr_writes);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
